FILE: hdl/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
// No dependencies; imported by tcw_cursor, text_console_writer and the testbench.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int MODE_W    = 2;
  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 32;
  localparam int CELL_W    = 16;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_HEX   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_BLANK = 8'h20;
  localparam logic [7:0] CODE_ZERO  = 8'h30;
  localparam logic [7:0] CODE_X     = 8'h78;
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  // "0x" plus sixteen digits
  localparam logic [4:0] PRINT_LEN = 5'd18;

  typedef struct packed {
    logic       put;
    logic       home;
    logic [7:0] code;
  } cur_cmd_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    if (nib < 4'd10) begin
      g = CODE_ZERO + {4'd0, nib};
    end else begin
      g = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/tcw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hdl/tcw_cursor.sv
// Cursor position registers and the put-character step (LF, CR, wrap, scroll).
// Depends on tcw_pkg.
`default_nettype none
module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tcw_pkg::cur_cmd_t                    cmd,
  output logic [$clog2(COLUMNS)-1:0]                col,
  output logic [$clog2(ROWS)-1:0]                   row,
  output logic [$clog2(ROWS*COLUMNS)-1:0]           addr,
  output logic                                      scroll
);
  import tcw_pkg::*;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(ROWS*COLUMNS);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W:0]   c;
  logic [ROW_W:0]   r;

  always_comb begin
    c      = {1'b0, col_r};
    r      = {1'b0, row_r};
    scroll = 1'b0;
    if (cmd.code == CODE_LF) begin
      c = '0;
      r = {1'b0, row_r} + (ROW_W+1)'(1);
    end else if (cmd.code == CODE_CR) begin
      c = '0;
    end else begin
      c = {1'b0, col_r} + (COL_W+1)'(1);
    end
    // wrap at the row end
    if (c == (COL_W+1)'(COLUMNS)) begin
      c = '0;
      r = {1'b0, row_r} + (ROW_W+1)'(1);
    end
    // past the last row: stay on the last row and scroll
    if (r == (ROW_W+1)'(ROWS)) begin
      r      = (ROW_W+1)'(ROWS - 1);
      scroll = cmd.put;
    end
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cmd.put) begin
      col_nxt = c[COL_W-1:0];
      row_nxt = r[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col  = col_r;
  assign row  = row_r;
  assign addr = ADDR_W'(row_r * COLUMNS) + ADDR_W'(col_r);

endmodule
`default_nettype wire

FILE: hdl/text_console_writer.sv
// Top level of the text console writer: sequencer, cell store and result register.
// Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
//  channel | ports                      | payload
//  --------+----------------------------+--------------------------------------------
//  input   | in_tvalid/in_tready        | tuser: mode; tdata: char_code, hex_value,
//          |                            |        read_row, read_col
//  result  | out_tvalid/out_tready      | tdata: cell_char, cell_attr, cursor_col,
//          |                            |        cursor_row
//  config  | cfg_valid/cfg_ready        | cfg_data: text_attribute
//
// States: put PUT then DONE (SCROLL and FILL between if it scrolls), read RD then DONE
// (DONE only if out of range), clear FILL then DONE, hex 18 puts then DONE, each may scroll.
// The scroll copy moves one cell per cycle through the single RAM port pair.
// Reset: the store is blanked in a sweep over all ROWS*COLUMNS cells; in_tready stays
// low meanwhile, cfg writes are taken at any time.
// Stalls: a finished result waits in the output register; the next input
// transaction is accepted meanwhile, and that item holds in DONE until the slot frees.
`default_nettype none
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [7:0] char_code, [71:8] hex_value, [76:72] read_row, [83:77] read_col
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] mode
  input  wire logic [tcw_pkg::MODE_W-1:0]       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row
  output logic [tcw_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [7:0]                       cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUT    = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // input fields
  logic [7:0]  in_char;
  logic [63:0] in_hex;
  logic [4:0]  in_row;
  logic [6:0]  in_col;
  logic        in_fire;
  logic        rd_in_range;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              init_r, init_nxt;
  logic [7:0]        fill_attr_r, fill_attr_nxt;
  logic [7:0]        attr_r;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic              hex_mode_r, hex_mode_nxt;
  logic [4:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  logic [7:0]            code_r, code_nxt;
  logic [63:0]           hex_r, hex_nxt;
  logic [7:0]            res_char_r, res_char_nxt;
  logic [7:0]            res_attr_r, res_attr_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // datapath
  logic [7:0]        put_code;
  logic [4:0]        idx_inc;
  logic              more_chars;
  logic              put_writes;
  cur_cmd_t          cur_cmd;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] cur_addr;
  logic              cur_scroll;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [CELL_W-1:0] ram_rd_data;

  assign in_char = in_tdata[7:0];
  assign in_hex  = in_tdata[71:8];
  assign in_row  = in_tdata[76:72];
  assign in_col  = in_tdata[83:77];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rd_in_range = (32'(in_row) < ROWS) && (32'(in_col) < COLUMNS);

  // character of the current put: literal code, or the hex sequence "0x" + digits
  always_comb begin
    if (!hex_mode_r) begin
      put_code = code_r;
    end else if (idx_r == 5'd0) begin
      put_code = CODE_ZERO;
    end else if (idx_r == 5'd1) begin
      put_code = CODE_X;
    end else begin
      put_code = hex_glyph(hex_r[63:60]);
    end
  end

  assign idx_inc    = idx_r + 5'd1;
  assign more_chars = hex_mode_r && (idx_r != PRINT_LEN);
  assign put_writes = (put_code != CODE_LF) && (put_code != CODE_CR);

  always_comb begin
    cur_cmd.put  = (state_r == S_PUT);
    cur_cmd.home = in_fire && (in_tuser == MODE_CLEAR);
    cur_cmd.code = put_code;
  end

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cur_cmd),
    .col    (cur_col),
    .row    (cur_row),
    .addr   (cur_addr),
    .scroll (cur_scroll)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // RAM port steering: a cell is {attribute, character}
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = cnt_r;
    ram_wr_data = {fill_attr_r, CODE_BLANK};
    ram_rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        ram_rd_addr = ADDR_W'(32'(in_row) * COLUMNS) + ADDR_W'(in_col);
      end
      S_PUT: begin
        ram_we      = put_writes;
        ram_wr_addr = cur_addr;
        ram_wr_data = {attr_r, put_code};
      end
      S_SCROLL: begin
        // read one row ahead, write back the cell read last cycle
        ram_we      = pend_r;
        ram_wr_addr = pend_addr_r;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = cnt_r + ADDR_W'(COLUMNS);
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    init_nxt      = init_r;
    fill_attr_nxt = fill_attr_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = cnt_r;
    hex_mode_nxt  = hex_mode_r;
    idx_nxt       = idx_r;
    code_nxt      = code_r;
    hex_nxt       = hex_r;
    res_char_nxt  = res_char_r;
    res_attr_nxt  = res_attr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          code_nxt     = in_char;
          hex_nxt      = in_hex;
          idx_nxt      = '0;
          hex_mode_nxt = (in_tuser == MODE_HEX);
          res_char_nxt = '0;
          res_attr_nxt = '0;
          case (in_tuser)
            MODE_PUT, MODE_HEX: begin
              state_nxt = S_PUT;
            end
            MODE_CLEAR: begin
              cnt_nxt       = '0;
              fill_attr_nxt = attr_r;
              state_nxt     = S_FILL;
            end
            MODE_READ: begin
              state_nxt = rd_in_range ? S_RD : S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_PUT: begin
        idx_nxt = idx_inc;
        if (idx_r >= 5'd2) begin
          hex_nxt = {hex_r[59:0], 4'h0};
        end
        if (cur_scroll) begin
          cnt_nxt       = '0;
          fill_attr_nxt = attr_r;
          state_nxt     = S_SCROLL;
        end else if (hex_mode_r && (idx_inc != PRINT_LEN)) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCROLL: begin
        if (cnt_r == COPY_END) begin
          // last pending copy is written this cycle; blank the bottom row next
          state_nxt = S_FILL;
        end else begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r;
          cnt_nxt       = cnt_r + ADDR_W'(1);
        end
      end
      S_FILL: begin
        if (cnt_r == LAST_ADDR) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else if (more_chars) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_RD: begin
        res_char_nxt = ram_rd_data[7:0];
        res_attr_nxt = ram_rd_data[15:8];
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, 5'(cur_row), 7'(cur_col), res_attr_r, res_char_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      cnt_r       <= '0;
      init_r      <= 1'b1;
      fill_attr_r <= RESET_ATTR;
      attr_r      <= RESET_ATTR;
      pend_r      <= 1'b0;
      hex_mode_r  <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      init_r      <= init_nxt;
      fill_attr_r <= fill_attr_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
      pend_r      <= pend_nxt;
      hex_mode_r  <= hex_mode_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    code_r      <= code_nxt;
    hex_r       <= hex_nxt;
    res_char_r  <= res_char_nxt;
    res_attr_r  <= res_attr_nxt;
    out_data_r  <= out_data_nxt;
  end

  // no input transaction before the reset sweep has blanked the store
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !in_tready)
    else $error("input accepted during reset sweep");

  // the cursor row never leaves the screen
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row) < ROWS)
    else $error("cursor row out of range");

  // scroll copy writes always trail its reads by one row
  a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL && pend_r) |-> (pend_addr_r < ram_rd_addr))
    else $error("scroll write overtakes read");

  // a result is only produced from the completion state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result outside completion");

endmodule
`default_nettype wire

FILE: verif/text_console_writer_tb.sv
// Self-checking testbench for text_console_writer: directed and random put, hex,
// clear and read transactions checked against a shadow screen kept in a small class.
// Depends on tcw_pkg and the text_console_writer RTL.
`default_nettype none
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int NCOLS = COLUMNS_DEF;
  localparam int NROWS = ROWS_DEF;
  localparam int CELLS = NCOLS * NROWS;
  localparam string HEX_DIGITS = "0123456789ABCDEF";
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 46;

  // One input transaction, split into its fields.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  code;
    logic [63:0] value;
    logic [4:0]  row;
    logic [6:0]  col;
  } console_item_t;

  // One result transaction, laid out as out_tdata[27:0].
  typedef struct packed {
    logic [4:0] cur_row;
    logic [6:0] cur_col;
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
  } readout_t;

  // Shadow of the screen store and cursor; predicts one readout per accepted item.
  class console_shadow;
    bit [7:0] glyph [CELLS];
    bit [7:0] color [CELLS];
    bit [7:0] text_attr;
    int       cur_col;
    int       cur_row;
    readout_t awaited_q[$];
    int       errors;

    function new();
      text_attr = RESET_ATTR;
      errors = 0;
      blank_screen();
    endfunction

    function void blank_screen();
      foreach (glyph[i]) begin
        glyph[i] = CODE_BLANK;
        color[i] = text_attr;
      end
      cur_col = 0;
      cur_row = 0;
    endfunction

    function void set_attr(bit [7:0] a);
      text_attr = a;
    endfunction

    function void scroll_up();
      for (int i = 0; i < CELLS - NCOLS; i++) begin
        glyph[i] = glyph[i + NCOLS];
        color[i] = color[i + NCOLS];
      end
      for (int i = CELLS - NCOLS; i < CELLS; i++) begin
        glyph[i] = CODE_BLANK;
        color[i] = text_attr;
      end
      cur_row = NROWS - 1;
    endfunction

    function void put_glyph(bit [7:0] code);
      if (code == CODE_LF) begin
        cur_col = 0;
        cur_row++;
      end else if (code == CODE_CR) begin
        cur_col = 0;
      end else begin
        // cursor row is always on screen here
        glyph[cur_row * NCOLS + cur_col] = code;
        color[cur_row * NCOLS + cur_col] = text_attr;
        cur_col++;
      end
      if (cur_col >= NCOLS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= NROWS) scroll_up();
    endfunction

    // Note an accepted input transaction and queue the readout it must produce.
    function void note_item(console_item_t it);
      readout_t r;
      r = '0;
      case (it.mode)
        MODE_PUT: put_glyph(it.code);
        MODE_HEX: begin
          put_glyph(CODE_ZERO);
          put_glyph(CODE_X);
          for (int s = 60; s >= 0; s -= 4) put_glyph(HEX_DIGITS[it.value[s +: 4]]);
        end
        MODE_CLEAR: blank_screen();
        default: begin
          // out-of-range reads leave the cell fields at zero
          if (it.row < NROWS && it.col < NCOLS) begin
            r.cell_char = glyph[it.row * NCOLS + it.col];
            r.cell_attr = color[it.row * NCOLS + it.col];
          end
        end
      endcase
      r.cur_col = 7'(cur_col);
      r.cur_row = 5'(cur_row);
      awaited_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Compare an accepted result with the oldest queued readout.
    task check_result(readout_t got);
      readout_t want;
      if (awaited_q.size() == 0) begin
        report_mismatch("unexpected result, cell_char", got.cell_char, 0);
        return;
      end
      want = awaited_q.pop_front();
      if (got.cell_char != want.cell_char)
        report_mismatch("cell_char", got.cell_char, want.cell_char);
      if (got.cell_attr != want.cell_attr)
        report_mismatch("cell_attr", got.cell_attr, want.cell_attr);
      if (got.cur_col != want.cur_col)
        report_mismatch("cursor_col", got.cur_col, want.cur_col);
      if (got.cur_row != want.cur_row)
        report_mismatch("cursor_row", got.cur_row, want.cur_row);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // [7:0] char_code, [71:8] hex_value, [76:72] read_row, [83:77] read_col
  logic [IN_DATA_W-1:0]  in_tdata;
  // [1:0] mode
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [7:0]            cfg_data;

  // Random idle bursts on both sides are allowed only while this is set.
  bit idle_on = 1'b1;

  console_shadow shadow;

  text_console_writer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs; well beyond the slowest legal run,
  // where most line feeds land on the bottom row and scroll.
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: hold out_tready low in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      out_tready <= (stall_left == 0);
    end
  end

  // Check every result transaction; values read here are the ones sampled at the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_result(readout_t'(out_tdata[27:0]));
  end

  // Item builders: fields that the mode ignores are still random.
  function automatic console_item_t noise_item();
    console_item_t it;
    it.mode  = MODE_PUT;
    it.code  = 8'($urandom);
    it.value = {$urandom, $urandom};
    it.row   = 5'($urandom);
    it.col   = 7'($urandom);
    return it;
  endfunction

  function automatic console_item_t put_item(logic [7:0] code);
    console_item_t it;
    it = noise_item();
    it.code = code;
    return it;
  endfunction

  function automatic console_item_t hex_item(logic [63:0] value);
    console_item_t it;
    it = noise_item();
    it.mode = MODE_HEX;
    it.value = value;
    return it;
  endfunction

  function automatic console_item_t clear_item();
    console_item_t it;
    it = noise_item();
    it.mode = MODE_CLEAR;
    return it;
  endfunction

  function automatic console_item_t read_item(logic [4:0] row, logic [6:0] col);
    console_item_t it;
    it = noise_item();
    it.mode = MODE_READ;
    it.row = row;
    it.col = col;
    return it;
  endfunction

  // Random mix: mostly text and line feeds, reads aimed near the cursor line.
  function automatic console_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return put_item(8'($urandom));
    if (pick < 52) return put_item(CODE_LF);
    if (pick < 57) return put_item(CODE_CR);
    if (pick < 70) return hex_item({$urandom, $urandom});
    if (pick < 72) return clear_item();
    if (pick < 86)
      return read_item(5'(shadow.cur_row), 7'($urandom_range(0, NCOLS - 1)));
    if (pick < 90) return read_item(5'($urandom), 7'($urandom));
    return read_item(5'($urandom_range(0, NROWS - 1)), 7'($urandom_range(0, NCOLS - 1)));
  endfunction

  // Drive one input transaction, with an optional idle burst ahead of it.
  task automatic send_item(console_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {4'b0, it.col, it.row, it.value, it.code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.note_item(it);
  endtask

  // Hold the input idle until every queued readout has arrived, then a short tail.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (shadow.awaited_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attr(bit [7:0] a);
    cfg_data  <= a;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow.set_attr(a);
  endtask

  initial begin
    int sent;
    int burst;
    bit [7:0] attr;
    shadow = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: blank store after reset, corner reads, odd codes, hex extremes, clear.
    send_item(read_item(5'd0, 7'd0));
    send_item(read_item(5'(NROWS - 1), 7'(NCOLS - 1)));
    send_item(read_item(5'(NROWS), 7'd0));
    send_item(read_item(5'd31, 7'd127));
    send_item(read_item(5'd0, 7'(NCOLS)));
    send_item(put_item(8'h00));
    send_item(put_item(8'hFF));
    send_item(put_item(8'h80));
    send_item(put_item(CODE_CR));
    send_item(put_item(8'h41));
    send_item(put_item(CODE_LF));
    send_item(read_item(5'd0, 7'd0));
    send_item(read_item(5'd0, 7'd1));
    send_item(read_item(5'd0, 7'd2));
    send_item(hex_item(64'h0));
    send_item(hex_item('1));
    send_item(hex_item(64'h0123_4567_89AB_CDEF));
    send_item(read_item(5'd1, 7'd0));
    send_item(read_item(5'd1, 7'd53));
    send_item(clear_item());
    send_item(read_item(5'd1, 7'd5));
    send_item(put_item(CODE_LF));

    // Random phases, one text attribute each; extremes first. The last phase runs
    // without idling, phases 1 and 4 too.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      attr = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
      write_attr(attr);
      idle_on = (p != PHASES - 1) && (p % 3 != 1);
      if (p % 2 == 0) send_item(clear_item());
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 3) begin
          // a run of line feeds pushes the cursor down and may reach the bottom and scroll
          burst = $urandom_range(5, 30);
          repeat (burst) send_item(put_item(CODE_LF));
          sent += burst;
        end else begin
          send_item(random_item());
          sent++;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: text_console_writer.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_cursor.sv
hdl/text_console_writer.sv
verif/text_console_writer_tb.sv
